// ===== rtl/ladder_keypad_debouncer_top_macros.svh =====
// ----------------------------------------------------------------------------
// Ladder keypad debouncer assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef LADDER_KEYPAD_DEBOUNCER_TOP_MACROS_SVH
`define LADDER_KEYPAD_DEBOUNCER_TOP_MACROS_SVH

// A condition that holds at every clock edge out of reset.
`define LKD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A condition that holds in the cycle after a trigger.
`define LKD_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lkd_pkg.sv =====
// ----------------------------------------------------------------------------
// Ladder keypad debouncer package
// Widths, defaults, command codes and phase type shared by the block.
// ----------------------------------------------------------------------------
package lkd_pkg;

  localparam int NUM_KEYS_DEF = 5;
  localparam int ADC_BITS_DEF = 12;

  localparam int SAMPLE_W    = 12;
  localparam int KEY_W       = 3;
  localparam int LEVEL_OUT_W = 3;
  localparam int CFG_W       = 4;
  localparam int CNT_W       = 4;

  localparam logic [CFG_W-1:0] CONFIRM_RESET = 4'd3;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic {
    PH_IDLE    = 1'b0,
    PH_PRESSED = 1'b1
  } phase_e;

endpackage

// ===== rtl/lkd_in_if.sv =====
// ----------------------------------------------------------------------------
// Ladder keypad debouncer input channel
// Valid/ready channel carrying a tick or read command and an ADC sample.
// ----------------------------------------------------------------------------
interface lkd_in_if;
  import lkd_pkg::*;

  logic                valid;
  logic                ready;
  logic                command;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output command, output sample, input ready);
  modport sink (input valid, input command, input sample, output ready);
endinterface

// ===== rtl/lkd_out_if.sv =====
// ----------------------------------------------------------------------------
// Ladder keypad debouncer output channel
// Valid/ready channel carrying one result beat per accepted item.
// ----------------------------------------------------------------------------
interface lkd_out_if;
  import lkd_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   key_valid;
  logic [KEY_W-1:0]       key_index;
  logic                   pressed_phase;
  logic [LEVEL_OUT_W-1:0] level;

  modport source (output valid, output key_valid, output key_index,
                  output pressed_phase, output level, input ready);
  modport sink (input valid, input key_valid, input key_index,
                input pressed_phase, input level, output ready);
endinterface

// ===== rtl/lkd_front.sv =====
// ----------------------------------------------------------------------------
// Ladder keypad debouncer front end
// Accepts input beats and quantizes each sample to a ladder level.
// ----------------------------------------------------------------------------
module lkd_front #(
  parameter int NUM_KEYS = lkd_pkg::NUM_KEYS_DEF,
  parameter int ADC_BITS = lkd_pkg::ADC_BITS_DEF,
  localparam int LvlW    = $clog2(NUM_KEYS + 1)
) (
  lkd_in_if.sink     in_i,
  input  logic       q_ready_i,
  output logic       push_o,
  output logic [LvlW:0] entry_o
);
  import lkd_pkg::*;

  localparam int SmpW = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
  localparam int CmpW = ADC_BITS + 6;
  localparam int Fs   = (1 << ADC_BITS) - 1;

  logic [SmpW-1:0] smp;
  logic [CmpW-1:0] prod;
  logic [LvlW-1:0] lvl;

  // Level is round(sample * NUM_KEYS / FS): count the thresholds
  // 2 * NUM_KEYS * sample >= (2k - 1) * FS that the sample passes.
  always_comb begin
    smp  = in_i.sample[SmpW-1:0];
    prod = CmpW'(smp) * CmpW'(2 * NUM_KEYS);
    lvl  = '0;
    for (int k = 1; k <= NUM_KEYS; k++) begin
      if (prod >= CmpW'((2 * k - 1) * Fs)) begin
        lvl = LvlW'(k);
      end
    end
  end

  assign in_i.ready = q_ready_i;
  assign push_o     = in_i.valid & q_ready_i;
  assign entry_o    = {in_i.command, lvl};

endmodule

// ===== rtl/lkd_queue.sv =====
// ----------------------------------------------------------------------------
// Ladder keypad debouncer queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module lkd_queue #(
  parameter int W = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  output logic         ready_o,
  input  logic         pop_i,
  output logic         nonempty_o,
  output logic [W-1:0] rdata_o
);
  logic [W-1:0] mem_q [2];
  logic [1:0]   count_q, count_d;
  logic         wr_q, rd_q;
  logic         do_push, do_pop;

  assign ready_o    = (count_q != 2'd2);
  assign nonempty_o = (count_q != 2'd0);
  assign do_push    = push_i & ready_o;
  assign do_pop     = pop_i & nonempty_o;
  assign rdata_o    = mem_q[rd_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/lkd_back.sv =====
// ----------------------------------------------------------------------------
// Ladder keypad debouncer back end
// Runs the debounce state machine and holds the result register.
// ----------------------------------------------------------------------------
module lkd_back #(
  parameter int NUM_KEYS = lkd_pkg::NUM_KEYS_DEF,
  localparam int LvlW    = $clog2(NUM_KEYS + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lkd_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                       q_nonempty_i,
  input  logic [LvlW:0]              q_entry_i,
  output logic                       pop_o,
  lkd_out_if.source                  out_o
);
  import lkd_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d, cnt_inc;
  logic [LvlW-1:0]        prev_q, prev_d, lvl;
  logic                   pend_v_q, pend_v_d;
  logic [KEY_W-1:0]       pend_k_q, pend_k_d;
  logic [CFG_W-1:0]       confirm_q;
  logic                   is_read, same;
  logic [3:0]             lvl_ext, prev_ext;
  logic                   out_valid_q;
  logic                   kv_q, kv_d;
  logic [KEY_W-1:0]       ki_q, ki_d;
  logic                   ph_q;
  logic [LEVEL_OUT_W-1:0] lv_q;

  assign pop_o   = q_nonempty_i & (~out_valid_q | out_o.ready);
  assign is_read = q_entry_i[LvlW];
  assign lvl     = q_entry_i[LvlW-1:0];
  assign lvl_ext = 4'(lvl);
  assign same    = (lvl == prev_q);
  assign cnt_inc = cnt_q + CNT_W'(1);

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    prev_d   = prev_q;
    pend_v_d = pend_v_q;
    pend_k_d = pend_k_q;
    kv_d     = 1'b0;
    ki_d     = '0;
    if (pop_o) begin
      if (is_read == CMD_READ) begin
        if (pend_v_q) begin
          kv_d     = 1'b1;
          ki_d     = pend_k_q;
          pend_v_d = 1'b0;
          pend_k_d = '0;
        end
      end else begin
        prev_d = lvl;
        cnt_d  = '0;
        case (phase_q)
          PH_IDLE: begin
            if (same && (lvl < LvlW'(NUM_KEYS))) begin
              cnt_d = cnt_inc;
              if (cnt_inc >= confirm_q) begin
                phase_d  = PH_PRESSED;
                pend_v_d = 1'b1;
                pend_k_d = lvl_ext[KEY_W-1:0];
                cnt_d    = '0;
              end
            end
          end
          PH_PRESSED: begin
            if (same && (lvl == LvlW'(NUM_KEYS))) begin
              cnt_d = cnt_inc;
              if (cnt_inc >= confirm_q) begin
                phase_d = PH_IDLE;
                cnt_d   = '0;
              end
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  assign prev_ext = 4'(prev_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      prev_q      <= '0;
      pend_v_q    <= 1'b0;
      pend_k_q    <= '0;
      confirm_q   <= CONFIRM_RESET;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      prev_q   <= prev_d;
      pend_v_q <= pend_v_d;
      pend_k_q <= pend_k_d;
      if (cfg_we_i) begin
        confirm_q <= cfg_wdata_i;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kv_q <= kv_d;
      ki_q <= ki_d;
      ph_q <= (phase_d == PH_PRESSED);
      lv_q <= prev_ext[LEVEL_OUT_W-1:0];
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.key_valid     = kv_q;
  assign out_o.key_index     = ki_q;
  assign out_o.pressed_phase = ph_q;
  assign out_o.level         = lv_q;

endmodule

// ===== rtl/ladder_keypad_debouncer_top.sv =====
// ----------------------------------------------------------------------------
// Ladder keypad debouncer top level
// Debounces a resistor-ladder keypad sampled through one ADC channel.
// ----------------------------------------------------------------------------
// The block takes one input beat every cycle unless the queue is full, and
// returns exactly one result beat for each, in order. A beat is a sample
// tick or a read of the pending key. The front end quantizes the sample in
// the cycle the beat is accepted and writes it to a two-entry queue; the
// back end pops one entry per cycle while the result register is free or
// being taken, updates the debounce state and loads the result register.
// The confirm count resets to 3 and should only be written while no beats
// are in flight.
module ladder_keypad_debouncer_top #(
  parameter int NUM_KEYS = lkd_pkg::NUM_KEYS_DEF,
  parameter int ADC_BITS = lkd_pkg::ADC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lkd_pkg::CFG_W-1:0] cfg_wdata_i,
  lkd_in_if.sink                    in_i,
  lkd_out_if.source                 out_o
);
  import lkd_pkg::*;

  localparam int LvlW = $clog2(NUM_KEYS + 1);

  logic          push, q_ready, q_nonempty, pop;
  logic [LvlW:0] wentry, rentry;

  lkd_front #(
    .NUM_KEYS (NUM_KEYS),
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .entry_o   (wentry)
  );

  lkd_queue #(
    .W (LvlW + 1)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .wdata_i    (wentry),
    .ready_o    (q_ready),
    .pop_i      (pop),
    .nonempty_o (q_nonempty),
    .rdata_o    (rentry)
  );

  lkd_back #(
    .NUM_KEYS (NUM_KEYS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .q_nonempty_i (q_nonempty),
    .q_entry_i    (rentry),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

// ===== rtl/lkd_checker.sv =====
// ----------------------------------------------------------------------------
// Ladder keypad debouncer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "ladder_keypad_debouncer_top_macros.svh"

module lkd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       key_valid,
  input logic [2:0] key_index,
  input logic       pressed_phase,
  input logic [2:0] level
);

  // A read that finds no pending key reports key zero.
  `LKD_ASSERT_ALWAYS(a_key_zero, !out_valid || key_valid || (key_index == 3'd0), "key_index set without key_valid")

  // With the result register empty the queue cannot be full.
  `LKD_ASSERT_ALWAYS(a_ready_when_empty, out_valid || in_ready, "input stalled with no result waiting")

  // A stalled result beat holds its payload.
  `LKD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(key_valid) && $stable(key_index) && $stable(pressed_phase) && $stable(level), "result beat changed while stalled")

endmodule

bind ladder_keypad_debouncer_top lkd_checker u_lkd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready      (in_i.ready),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .key_valid     (out_o.key_valid),
  .key_index     (out_o.key_index),
  .pressed_phase (out_o.pressed_phase),
  .level         (out_o.level)
);

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Ladder keypad debouncer testbench
// Sends sample ticks and key reads in random bursts to a receiver that
// stalls at random, and checks every result beat against a software
// debouncer or a directed expected beat. Confirm count settings are changed
// only while nothing is in flight.
// ----------------------------------------------------------------------------
module tb_top;
  import lkd_pkg::*;

  localparam int NUM_KEYS    = NUM_KEYS_DEF;
  localparam int TOP_LEVEL   = NUM_KEYS;
  localparam int FULL_SCALE  = (1 << ADC_BITS_DEF) - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 270;

  typedef struct packed {
    logic                   key_valid;
    logic [KEY_W-1:0]       key_index;
    logic                   pressed_phase;
    logic [LEVEL_OUT_W-1:0] level;
  } key_beat_t;

  typedef struct packed {
    logic                command;
    logic [SAMPLE_W-1:0] sample;
    logic                typed;
    key_beat_t           beat;
  } stim_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  lkd_in_if  in_ch();
  lkd_out_if out_ch();

  ladder_keypad_debouncer_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  logic [CFG_W-1:0]       dbn_confirm;
  phase_e                 dbn_phase;
  logic [CNT_W-1:0]       dbn_count;
  logic [LEVEL_OUT_W-1:0] dbn_prev_level;
  logic                   dbn_pending;
  logic [KEY_W-1:0]       dbn_key;

  key_beat_t   expected_beats[$];
  stim_row_t   directed_rows[$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned burst_left;
  bit          paused;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic int unsigned ladder_level(logic [SAMPLE_W-1:0] smp);
    int unsigned s;
    s = smp;
    return (2 * s * NUM_KEYS + FULL_SCALE) / (2 * FULL_SCALE);
  endfunction

  function automatic logic [SAMPLE_W-1:0] sample_for_level(int unsigned lvl);
    logic [SAMPLE_W-1:0] s;
    do s = SAMPLE_W'($urandom_range(0, FULL_SCALE)); while (ladder_level(s) != lvl);
    return s;
  endfunction

  function automatic key_beat_t beat_of(logic kv, logic [KEY_W-1:0] key, phase_e ph,
                                        logic [LEVEL_OUT_W-1:0] lvl);
    key_beat_t b;
    b.key_valid     = kv;
    b.key_index     = key;
    b.pressed_phase = ph;
    b.level         = lvl;
    return b;
  endfunction

  function automatic key_beat_t debounce_step(logic cmd, logic [SAMPLE_W-1:0] smp);
    key_beat_t   b;
    int unsigned lvl;
    b = '0;
    if (cmd == CMD_TICK) begin
      lvl = ladder_level(smp);
      if (dbn_phase == PH_IDLE) begin
        if (lvl == dbn_prev_level && lvl < TOP_LEVEL) begin
          dbn_count = dbn_count + 1'b1;
          if (dbn_count >= dbn_confirm) begin
            dbn_phase   = PH_PRESSED;
            dbn_pending = 1'b1;
            dbn_key     = lvl[KEY_W-1:0];
            dbn_count   = '0;
          end
        end else begin
          dbn_count = '0;
        end
      end else begin
        if (lvl == dbn_prev_level && lvl == TOP_LEVEL) begin
          dbn_count = dbn_count + 1'b1;
          if (dbn_count >= dbn_confirm) begin
            dbn_phase = PH_IDLE;
            dbn_count = '0;
          end
        end else begin
          dbn_count = '0;
        end
      end
      dbn_prev_level = lvl[LEVEL_OUT_W-1:0];
    end else if (dbn_pending) begin
      b.key_valid = 1'b1;
      b.key_index = dbn_key;
      dbn_pending = 1'b0;
      dbn_key     = '0;
    end
    b.pressed_phase = dbn_phase;
    b.level         = dbn_prev_level;
    return b;
  endfunction

  task automatic send_beat(logic cmd, logic [SAMPLE_W-1:0] smp, logic typed,
                           key_beat_t typed_beat);
    int unsigned gap;
    bit          taken;
    key_beat_t   predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 60);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.sample  <= smp;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      if (in_ch.ready) begin
        taken     = 1'b1;
        predicted = debounce_step(cmd, smp);
        expected_beats.push_back(typed ? typed_beat : predicted);
      end
      @(posedge clk_i);
    end
    burst_left--;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_confirm(logic [CFG_W-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dbn_confirm = value;
    @(posedge clk_i);
  endtask

  task automatic run_random_phase(int unsigned n_items);
    int unsigned sent;
    int unsigned lvl;
    int unsigned run_len;
    int unsigned k;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_beat(CMD_TICK, SAMPLE_W'($urandom_range(0, FULL_SCALE)), 1'b0, '0);
        sent++;
      end else begin
        if (dbn_phase == PH_PRESSED) begin
          lvl = ($urandom_range(0, 9) < 6) ? TOP_LEVEL : $urandom_range(0, NUM_KEYS - 1);
        end else begin
          lvl = ($urandom_range(0, 4) == 0) ? TOP_LEVEL : $urandom_range(0, NUM_KEYS - 1);
        end
        if ($urandom_range(0, 4) == 0) begin
          run_len = $urandom_range(1, dbn_confirm + 1);
        end else begin
          run_len = dbn_confirm + $urandom_range(1, 3);
        end
        for (k = 0; k < run_len; k++) begin
          if ($urandom_range(0, 7) == 0) begin
            send_beat(CMD_READ, SAMPLE_W'($urandom_range(0, FULL_SCALE)), 1'b0, '0);
            sent++;
          end
          send_beat(CMD_TICK, sample_for_level(lvl), 1'b0, '0);
          sent++;
        end
      end
      if (!paused && sent >= n_items / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
  endtask

  task automatic report_mismatch(string what, key_beat_t want, key_beat_t got);
    errors++;
    if (errors <= 10) begin
      $display("%s: expected valid=%0d key=%0d phase=%0d level=%0d, got valid=%0d key=%0d phase=%0d level=%0d",
               what, want.key_valid, want.key_index, want.pressed_phase, want.level,
               got.key_valid, got.key_index, got.pressed_phase, got.level);
    end
  endtask

  initial begin
    int unsigned mode;
    int unsigned span;
    out_ch.ready = 1'b0;
    span = 0;
    mode = 0;
    forever begin
      @(posedge clk_i);
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(10, 80);
      end
      span--;
      case (mode)
        0: begin
          out_ch.ready <= 1'b1;
        end
        1: begin
          out_ch.ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          out_ch.ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_ch.ready <= (span % 5 != 0);
        end
      endcase
    end
  end

  // Outputs and ready are stable at the falling edge, so a beat seen here is
  // the one taken at the next rising edge.
  always @(negedge clk_i) begin
    key_beat_t got;
    key_beat_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = beat_of(out_ch.key_valid, out_ch.key_index, phase_e'(out_ch.pressed_phase),
                    out_ch.level);
      if (expected_beats.size() == 0) begin
        report_mismatch("Unexpected result beat", '0, got);
      end else begin
        want = expected_beats.pop_front();
        if (got.key_valid !== want.key_valid || got.key_index !== want.key_index ||
            got.pressed_phase !== want.pressed_phase || got.level !== want.level) begin
          report_mismatch("Result mismatch", want, got);
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_TICK;
    in_ch.sample  = '0;
    errors        = 0;
    burst_left    = 0;
    paused        = 1'b0;

    dbn_confirm    = CONFIRM_RESET;
    dbn_phase      = PH_IDLE;
    dbn_count      = '0;
    dbn_prev_level = '0;
    dbn_pending    = 1'b0;
    dbn_key        = '0;

    directed_rows.push_back({CMD_READ, 12'hFFF, 1'b1, beat_of(1'b0, 3'd0, PH_IDLE, 3'd0)});
    directed_rows.push_back({CMD_TICK, 12'd0,   1'b1, beat_of(1'b0, 3'd0, PH_IDLE, 3'd0)});
    directed_rows.push_back({CMD_TICK, 12'hFFF, 1'b1, beat_of(1'b0, 3'd0, PH_IDLE, 3'd5)});
    directed_rows.push_back({CMD_TICK, 12'd1,   1'b0, key_beat_t'('0)});
    repeat (3) directed_rows.push_back({CMD_TICK, 12'd0, 1'b0, key_beat_t'('0)});
    directed_rows.push_back({CMD_TICK, 12'd2048, 1'b0, key_beat_t'('0)});
    repeat (4) directed_rows.push_back({CMD_TICK, 12'hFFF, 1'b0, key_beat_t'('0)});
    directed_rows.push_back({CMD_READ, 12'd0, 1'b1, beat_of(1'b1, 3'd0, PH_IDLE, 3'd5)});
    repeat (4) directed_rows.push_back({CMD_TICK, 12'd3300, 1'b0, key_beat_t'('0)});
    repeat (4) directed_rows.push_back({CMD_TICK, 12'hFFF, 1'b0, key_beat_t'('0)});
    repeat (4) directed_rows.push_back({CMD_TICK, 12'd1000, 1'b0, key_beat_t'('0)});
    directed_rows.push_back({CMD_READ, 12'hAAA, 1'b1, beat_of(1'b1, 3'd1, PH_PRESSED, 3'd1)});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_beat(row.command, row.sample, row.typed, row.beat);
    end

    write_confirm(4'd1);
    run_random_phase(PHASE_ITEMS);
    write_confirm(4'd15);
    run_random_phase(PHASE_ITEMS);
    write_confirm(4'd0);
    run_random_phase(PHASE_ITEMS);
    write_confirm(4'd2);
    run_random_phase(PHASE_ITEMS);
    write_confirm(CFG_W'($urandom_range(0, 15)));
    run_random_phase(PHASE_ITEMS);
    write_confirm(4'd7);
    run_random_phase(PHASE_ITEMS);

    drain_results();
    repeat (8) @(posedge clk_i);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== ladder_keypad_debouncer_top.f =====
+incdir+rtl
rtl/lkd_pkg.sv
rtl/lkd_in_if.sv
rtl/lkd_out_if.sv
rtl/lkd_front.sv
rtl/lkd_queue.sv
rtl/lkd_back.sv
rtl/ladder_keypad_debouncer_top.sv
rtl/lkd_checker.sv
verif/tb_top.sv
